### rtl/servo_telemetry_deframer_assert.svh
// Assertion macros shared by the servo telemetry deframer RTL.
// Plain text macros only; no package or module dependencies.
`ifndef SERVO_TELEMETRY_DEFRAMER_ASSERT_SVH
`define SERVO_TELEMETRY_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define STDF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define STDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/stdf_pkg.sv
// Shared types, register codes and scaling function of the servo telemetry deframer.
// No dependencies; used by rtl/servo_telemetry_deframer.sv.
package stdf_pkg;

    // Framing constants
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam int         REC_LEN  = 7;

    // Configuration register indexes
    localparam int         CFG_IDX_W         = 2;
    localparam int         CFG_DATA_W        = 18;
    localparam logic [1:0] CFG_SERVO_COUNT   = 2'd0;
    localparam logic [1:0] CFG_POSITION_GAIN = 2'd1;
    localparam logic [1:0] CFG_SPEED_GAIN    = 2'd2;
    localparam logic [1:0] CFG_LOAD_GAIN     = 2'd3;

    // Register reset values
    localparam logic [4:0]  RST_SERVO_COUNT   = 5'd1;
    localparam logic [17:0] RST_POSITION_GAIN = 18'd12868;
    localparam logic [17:0] RST_SPEED_GAIN    = 18'd81920;
    localparam logic [17:0] RST_LOAD_GAIN     = 18'd81920;

    // Deframer phase, one-hot
    typedef enum logic [1:0] {
        ST_HUNT = 2'b01,
        ST_DATA = 2'b10
    } phase_t;

    // Scale a raw 16-bit reading: floor(((2*raw - 65535) * gain) / 65536), Q.12
    function automatic logic signed [18:0] scale_raw(input logic [15:0] raw,
                                                     input logic [17:0] gain);
        logic signed [17:0] centered;
        logic signed [18:0] gain_s;
        logic signed [36:0] prod;
        centered = $signed({1'b0, raw, 1'b0}) - 18'sd65535;
        gain_s   = $signed({1'b0, gain});
        prod     = centered * gain_s;
        // Arithmetic shift by 16 keeps floor rounding; magnitude fits in 19 bits
        return prod[34:16];
    endfunction

endpackage

### rtl/servo_telemetry_deframer.sv
// Servo telemetry deframer: header hunt, record collection and gain scaling.
// Depends on rtl/stdf_pkg.sv and rtl/servo_telemetry_deframer_assert.svh.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one received byte
//   per word. The block hunts for HEADER_BYTES consecutive 0xFF bytes, then
//   collects 7-byte records (id, position, speed, load; values little-endian).
//   Output channel (out_valid / out_stall) carries one scaled record per word,
//   with frame_last set on the final record of the frame.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data) is
//   always ready; write it only while no record is in flight.
// Throughput: one byte per clock while in_stall is low. Timing: the record
//   appears in the cycle after its seventh byte is accepted; the three gain
//   multipliers sit between the byte registers and the output register.
// Stall: the output register holds its word while out_stall is high; in_stall
//   rises only when a seventh byte would overwrite a word still held there.
// Reset: asynchronous, hunting for a header, output empty, registers at their
//   default values. No clearing pass is needed.
module servo_telemetry_deframer #(
    parameter int MAX_SERVOS   = 16,
    parameter int HEADER_BYTES = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // byte input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           rx_byte,
    // record output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           servo_id,
    output logic [3:0]                           slot,
    output logic signed [18:0]                   position,
    output logic signed [18:0]                   speed,
    output logic signed [18:0]                   load,
    output logic                                 frame_last,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [stdf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [stdf_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "servo_telemetry_deframer_assert.svh"

    localparam int SLOT_W  = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;
    localparam int CNT_W   = ($clog2(MAX_SERVOS + 1) > 5) ? $clog2(MAX_SERVOS + 1) : 5;
    localparam int HR_W    = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int BPOS_W  = $clog2(stdf_pkg::REC_LEN);
    localparam int NSTORE  = stdf_pkg::REC_LEN - 1;

    // Configuration registers
    logic [4:0]  servo_count_reg;
    logic [17:0] position_gain_reg;
    logic [17:0] speed_gain_reg;
    logic [17:0] load_gain_reg;

    // Deframer state
    stdf_pkg::phase_t  phase_reg, phase_next;
    logic [HR_W-1:0]   hrun_reg, hrun_next;
    logic [BPOS_W-1:0] bpos_reg, bpos_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [7:0]        rec_reg [NSTORE];

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         id_reg;
    logic [3:0]         slot_out_reg;
    logic signed [18:0] pos_reg;
    logic signed [18:0] spd_reg;
    logic signed [18:0] load_reg;
    logic               last_reg;

    // Combinational helpers
    logic              in_acc;
    logic              emit_pos;
    logic              out_load;
    logic [HR_W:0]     hrun_plus;
    logic [CNT_W-1:0]  count_raw;
    logic [CNT_W-1:0]  count_clamped;
    logic [CNT_W-1:0]  slot_plus;
    logic              last_rec;
    logic [7:0]        slot_wide;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_count_reg   <= stdf_pkg::RST_SERVO_COUNT;
            position_gain_reg <= stdf_pkg::RST_POSITION_GAIN;
            speed_gain_reg    <= stdf_pkg::RST_SPEED_GAIN;
            load_gain_reg     <= stdf_pkg::RST_LOAD_GAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                stdf_pkg::CFG_SERVO_COUNT:   servo_count_reg   <= cfg_data[4:0];
                stdf_pkg::CFG_POSITION_GAIN: position_gain_reg <= cfg_data;
                stdf_pkg::CFG_SPEED_GAIN:    speed_gain_reg    <= cfg_data;
                stdf_pkg::CFG_LOAD_GAIN:     load_gain_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the input only when a finished record would overwrite a stalled word
    assign emit_pos = (phase_reg == stdf_pkg::ST_DATA)
                      && (bpos_reg == BPOS_W'(stdf_pkg::REC_LEN - 1));
    assign in_stall = emit_pos && out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign out_load = in_acc && emit_pos;

    // Clamp the record count to 1..MAX_SERVOS and detect the final record
    always_comb
    begin
        count_raw = CNT_W'(servo_count_reg);
        if (count_raw == '0)
            count_clamped = CNT_W'(1);
        else if (count_raw > CNT_W'(MAX_SERVOS))
            count_clamped = CNT_W'(MAX_SERVOS);
        else
            count_clamped = count_raw;
        slot_plus = CNT_W'(slot_reg) + CNT_W'(1);
        last_rec  = (slot_plus >= count_clamped);
        hrun_plus = (HR_W + 1)'(hrun_reg) + (HR_W + 1)'(1);
        slot_wide = 8'(slot_reg);
    end

    // Advance the header hunt and the record byte position
    always_comb
    begin
        phase_next = phase_reg;
        hrun_next  = hrun_reg;
        bpos_next  = bpos_reg;
        slot_next  = slot_reg;
        if (in_acc)
        begin
            unique case (phase_reg)
                stdf_pkg::ST_HUNT:
                begin
                    if (rx_byte == stdf_pkg::HDR_BYTE)
                    begin
                        if (hrun_plus >= (HR_W + 1)'(HEADER_BYTES))
                        begin
                            hrun_next  = '0;
                            phase_next = stdf_pkg::ST_DATA;
                            bpos_next  = '0;
                            slot_next  = '0;
                        end
                        else
                        begin
                            hrun_next = hrun_plus[HR_W-1:0];
                        end
                    end
                    else
                    begin
                        hrun_next = '0;
                    end
                end
                stdf_pkg::ST_DATA:
                begin
                    if (emit_pos)
                    begin
                        bpos_next = '0;
                        if (last_rec)
                        begin
                            slot_next  = '0;
                            phase_next = stdf_pkg::ST_HUNT;
                            hrun_next  = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + SLOT_W'(1);
                        end
                    end
                    else
                    begin
                        bpos_next = bpos_reg + BPOS_W'(1);
                    end
                end
                default:
                begin
                    phase_next = stdf_pkg::ST_HUNT;
                    hrun_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= stdf_pkg::ST_HUNT;
            hrun_reg  <= '0;
            bpos_reg  <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hrun_reg  <= hrun_next;
            bpos_reg  <= bpos_next;
            slot_reg  <= slot_next;
        end
    end

    // Store the first six bytes of each record
    always_ff @(posedge clk)
    begin
        if (in_acc && (phase_reg == stdf_pkg::ST_DATA) && !emit_pos)
            rec_reg[bpos_reg] <= rx_byte;
    end

    // Output word valid: load on the seventh byte, drop once taken
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Scale the three readings into the output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            id_reg       <= rec_reg[0];
            slot_out_reg <= slot_wide[3:0];
            pos_reg      <= stdf_pkg::scale_raw({rec_reg[2], rec_reg[1]}, position_gain_reg);
            spd_reg      <= stdf_pkg::scale_raw({rec_reg[4], rec_reg[3]}, speed_gain_reg);
            load_reg     <= stdf_pkg::scale_raw({rx_byte, rec_reg[5]}, load_gain_reg);
            last_reg     <= last_rec;
        end
    end

    assign out_valid  = out_valid_reg;
    assign servo_id   = id_reg;
    assign slot       = slot_out_reg;
    assign position   = pos_reg;
    assign speed      = spd_reg;
    assign load       = load_reg;
    assign frame_last = last_reg;

    // Checks on the deframer's own control
    `STDF_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid_reg && out_stall && emit_pos, "input stalled without a held output word")
    `STDF_ASSERT_NEXT(a_frame_end, clk, rst_n, out_load && last_rec, out_valid_reg && last_reg && (phase_reg == stdf_pkg::ST_HUNT), "final record did not end the frame")
    `STDF_ASSERT_NOW(a_hunt_clear, clk, rst_n, phase_reg == stdf_pkg::ST_HUNT, (bpos_reg == '0) && (slot_reg == '0), "record counters not cleared while hunting")

endmodule
